>>> hw/rtl/bfrf_pkg.sv
// Shared types, field widths and constants for the bitplane frame store.
package bfrf_pkg;

  localparam int MAX_WIDTH_DEF   = 512;
  localparam int MAX_HEIGHT_DEF  = 256;
  localparam int STORE_BYTES_DEF = 16384;

  localparam int SCR_W_W     = 10;
  localparam int SCR_H_W     = 9;
  localparam int POS_X_W     = 9;
  localparam int POS_Y_W     = 8;
  localparam int RECT_W_W    = 10;
  localparam int RECT_H_W    = 9;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 10;
  localparam int STRIDE_W    = 7;

  localparam logic [SCR_W_W-1:0] SCR_W_RESET = 10'd400;
  localparam logic [SCR_H_W-1:0] SCR_H_RESET = 9'd256;

  localparam logic [7:0] BYTE_ONES  = 8'hFF;
  localparam logic [7:0] BYTE_ZEROS = 8'h00;
  localparam logic [7:0] LEFT_BIT   = 8'h80;

  typedef enum logic [1:0] {
    REQ_WRITE,
    REQ_READ,
    REQ_FILL,
    REQ_CLEAR
  } req_type_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SCREEN_WIDTH,
    CFG_SCREEN_HEIGHT
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_EVAL,
    ST_PIX,
    ST_FILL,
    ST_FILL_WR,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic [SCR_W_W-1:0]  w;
    logic [SCR_H_W-1:0]  ch;
    logic [STRIDE_W-1:0] stride;
  } geom_t;

endpackage

>>> hw/rtl/bfrf_if.sv
// Request and response channel interfaces.
interface bfrf_req_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       req_type;
  logic [bfrf_pkg::POS_X_W-1:0]     pos_x;
  logic [bfrf_pkg::POS_Y_W-1:0]     pos_y;
  logic [bfrf_pkg::RECT_W_W-1:0]    rect_width;
  logic [bfrf_pkg::RECT_H_W-1:0]    rect_height;
  logic                             pixel_in;

  modport source (output valid, req_type, pos_x, pos_y, rect_width, rect_height, pixel_in,
                  input ready);
  modport sink   (input valid, req_type, pos_x, pos_y, rect_width, rect_height, pixel_in,
                  output ready);
endinterface

interface bfrf_rsp_if;
  logic valid;
  logic ready;
  logic pixel_out;
  logic status;

  modport source (output valid, pixel_out, status, input ready);
  modport sink   (input valid, pixel_out, status, output ready);
endinterface

>>> hw/rtl/bitplane_framebuffer_rect_fill.sv
// Top level: one-bit-per-pixel frame store with pixel access, rectangle fill and clear.
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    req_type pos_x pos_y rect_width rect_height pixel_in
//   rsp      out  valid/ready    pixel_out status
//   cfg      in   cfg_we         cfg_index cfg_data (screen_width, screen_height)
//
// Pixel write or read: states ST_MUL (multiply), ST_EVAL (bounds check and RAM read),
// ST_PIX (read-modify-write or read capture) and ST_RESP; out of bounds skips ST_PIX.
// Fill: ST_MUL and ST_EVAL, then per row each whole byte is written in ST_FILL and
// each partial edge byte is read there and written in ST_FILL_WR; an empty or
// out-of-bounds fill goes straight to ST_RESP. Clear: one byte per cycle through the
// single RAM port. The next item is accepted after the result is loaded.
// Reset runs the same clearing pass with req.ready low.
// A finished result waits in the output register while the next item is accepted.
module bitplane_framebuffer_rect_fill #(
  parameter int MAX_WIDTH   = bfrf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = bfrf_pkg::MAX_HEIGHT_DEF,
  parameter int STORE_BYTES = bfrf_pkg::STORE_BYTES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  bfrf_req_if.sink                            req,
  bfrf_rsp_if.source                          rsp,
  input  logic                                cfg_we,
  input  logic [bfrf_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [bfrf_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int AddrW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

  logic [bfrf_pkg::SCR_W_W-1:0] screen_width;
  logic [bfrf_pkg::SCR_H_W-1:0] screen_height;
  bfrf_pkg::geom_t              geom;

  logic             mem_en;
  logic             mem_we;
  logic [AddrW-1:0] mem_addr;
  logic [7:0]       mem_wdata;
  logic [7:0]       mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= bfrf_pkg::SCR_W_RESET;
      screen_height <= bfrf_pkg::SCR_H_RESET;
    end else if (cfg_we) begin
      unique case (bfrf_pkg::cfg_index_t'(cfg_index))
        bfrf_pkg::CFG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        bfrf_pkg::CFG_SCREEN_HEIGHT: screen_height <= cfg_data[bfrf_pkg::SCR_H_W-1:0];
        default: begin
        end
      endcase
    end
  end

  bfrf_geom #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_geom (
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .geom          (geom)
  );

  bfrf_seq #(
    .STORE_BYTES (STORE_BYTES),
    .AddrW       (AddrW)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .geom      (geom),
    .req       (req),
    .rsp       (rsp),
    .mem_en    (mem_en),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  bfrf_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_ram (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

endmodule

>>> hw/rtl/bfrf_ram.sv
// Generic single-port synchronous RAM with registered read.
module bfrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  logic                                        clk,
  input  logic                                        en,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                            wdata,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

>>> hw/rtl/bfrf_geom.sv
// Active screen geometry: width rounding and saturation, height saturation, row stride.
module bfrf_geom #(
  parameter int MAX_WIDTH  = bfrf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bfrf_pkg::MAX_HEIGHT_DEF
) (
  input  logic [bfrf_pkg::SCR_W_W-1:0] screen_width,
  input  logic [bfrf_pkg::SCR_H_W-1:0] screen_height,
  output bfrf_pkg::geom_t              geom
);

  localparam int MaxW = MAX_WIDTH & ~7;

  logic [bfrf_pkg::SCR_W_W-1:0] cw;
  logic [bfrf_pkg::SCR_W_W-1:0] cw_sat;

  always_comb begin
    cw          = {screen_width[bfrf_pkg::SCR_W_W-1:3], 3'b000};
    cw_sat      = (32'(cw) > 32'(MaxW)) ? bfrf_pkg::SCR_W_W'(MaxW) : cw;
    geom.w      = cw_sat;
    geom.stride = cw_sat[bfrf_pkg::SCR_W_W-1:3];
    geom.ch     = (32'(screen_height) > 32'(MAX_HEIGHT)) ?
                  bfrf_pkg::SCR_H_W'(MAX_HEIGHT) : screen_height;
  end

endmodule

>>> hw/rtl/bfrf_seq.sv
// Request sequencer: bounds check, read-modify-write of pixels, fill walk and clear sweep.
module bfrf_seq #(
  parameter int STORE_BYTES = bfrf_pkg::STORE_BYTES_DEF,
  parameter int AddrW       = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  bfrf_pkg::geom_t      geom,
  bfrf_req_if.sink             req,
  bfrf_rsp_if.source           rsp,
  output logic                 mem_en,
  output logic                 mem_we,
  output logic [AddrW-1:0]     mem_addr,
  output logic [7:0]           mem_wdata,
  input  logic [7:0]           mem_rdata
);

  localparam logic [AddrW-1:0] ClrLast = AddrW'(STORE_BYTES - 1);
  localparam int SW = bfrf_pkg::STRIDE_W;

  bfrf_pkg::state_t    state;
  bfrf_pkg::state_t    state_next;
  bfrf_pkg::req_type_t rtype;

  logic [AddrW-1:0]                 clr_cnt;
  logic                             clr_resp;
  logic [bfrf_pkg::POS_X_W-1:0]     px;
  logic [bfrf_pkg::POS_Y_W-1:0]     py;
  logic [bfrf_pkg::RECT_W_W-1:0]    rw;
  logic [bfrf_pkg::RECT_H_W-1:0]    rh;
  logic                             val;
  logic [16:0]                      lim_prod;
  logic [14:0]                      base_prod;
  logic [AddrW-1:0]                 cur_addr;
  logic [7:0]                       cur_mask;
  logic [SW-1:0]                    fb;
  logic [SW-1:0]                    lb;
  logic [SW-1:0]                    b;
  logic [7:0]                       lo_mask;
  logic [7:0]                       hi_mask;
  logic [bfrf_pkg::RECT_H_W-1:0]    rows;
  logic [AddrW-1:0]                 row_base;
  logic                             res_pix;
  logic                             res_err;
  logic                             out_valid;
  logic                             out_pix;
  logic                             out_err;

  logic [9:0]        n;
  logic              is_pix;
  logic              rows_ok;
  logic              pix_ok;
  logic              fill_ok;
  logic              fill_empty;
  logic [10:0]       last;
  logic [AddrW-1:0]  pix_addr;
  logic [7:0]        fill_mask;
  logic [AddrW-1:0]  fill_addr;
  logic              mask_full;
  logic              walk_done;
  logic [7:0]        rmw_data;
  logic              out_free;

  // Row count that must fit: y+1 for a pixel, y+height for a fill.
  always_comb begin
    is_pix     = (rtype == bfrf_pkg::REQ_WRITE) || (rtype == bfrf_pkg::REQ_READ);
    n          = (rtype == bfrf_pkg::REQ_FILL) ? 10'(py) + 10'(rh) : 10'(py) + 10'd1;
    rows_ok    = (n <= 10'(geom.ch)) && (32'(lim_prod) <= 32'(STORE_BYTES));
    pix_ok     = (10'(px) < geom.w) && rows_ok;
    fill_ok    = (11'(px) + 11'(rw) <= 11'(geom.w)) && rows_ok &&
                 ((geom.stride != '0) || (n == '0));
    fill_empty = (rw == '0) || (rh == '0);
    last       = 11'(px) + 11'(rw) - 11'd1;
    pix_addr   = AddrW'(base_prod) + AddrW'(px[bfrf_pkg::POS_X_W-1:3]);
    fill_mask  = ((b == fb) ? lo_mask : bfrf_pkg::BYTE_ONES) &
                 ((b == lb) ? hi_mask : bfrf_pkg::BYTE_ONES);
    fill_addr  = row_base + AddrW'(b);
    mask_full  = (fill_mask == bfrf_pkg::BYTE_ONES);
    walk_done  = (b == lb) && (rows == bfrf_pkg::RECT_H_W'(1));
    rmw_data   = val ? (mem_rdata | cur_mask) : (mem_rdata & ~cur_mask);
    out_free   = !out_valid || rsp.ready;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bfrf_pkg::ST_CLEAR: begin
        if (clr_cnt == ClrLast) begin
          state_next = clr_resp ? bfrf_pkg::ST_RESP : bfrf_pkg::ST_IDLE;
        end
      end
      bfrf_pkg::ST_IDLE: begin
        if (req.valid) begin
          state_next = (bfrf_pkg::req_type_t'(req.req_type) == bfrf_pkg::REQ_CLEAR) ?
                       bfrf_pkg::ST_CLEAR : bfrf_pkg::ST_MUL;
        end
      end
      bfrf_pkg::ST_MUL: state_next = bfrf_pkg::ST_EVAL;
      bfrf_pkg::ST_EVAL: begin
        if (is_pix) begin
          state_next = pix_ok ? bfrf_pkg::ST_PIX : bfrf_pkg::ST_RESP;
        end else begin
          state_next = (fill_ok && !fill_empty) ? bfrf_pkg::ST_FILL : bfrf_pkg::ST_RESP;
        end
      end
      bfrf_pkg::ST_PIX: state_next = bfrf_pkg::ST_RESP;
      bfrf_pkg::ST_FILL: begin
        if (!mask_full) begin
          state_next = bfrf_pkg::ST_FILL_WR;
        end else if (walk_done) begin
          state_next = bfrf_pkg::ST_RESP;
        end
      end
      bfrf_pkg::ST_FILL_WR: begin
        state_next = walk_done ? bfrf_pkg::ST_RESP : bfrf_pkg::ST_FILL;
      end
      bfrf_pkg::ST_RESP: begin
        if (out_free) begin
          state_next = bfrf_pkg::ST_IDLE;
        end
      end
      default: state_next = bfrf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready = (state == bfrf_pkg::ST_IDLE);
    mem_en    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = cur_addr;
    mem_wdata = rmw_data;
    unique case (state)
      bfrf_pkg::ST_CLEAR: begin
        mem_en    = 1'b1;
        mem_we    = 1'b1;
        mem_addr  = clr_cnt;
        mem_wdata = bfrf_pkg::BYTE_ZEROS;
      end
      bfrf_pkg::ST_EVAL: begin
        mem_en   = is_pix && pix_ok;
        mem_addr = pix_addr;
      end
      bfrf_pkg::ST_PIX: begin
        mem_en = (rtype == bfrf_pkg::REQ_WRITE);
        mem_we = (rtype == bfrf_pkg::REQ_WRITE);
      end
      bfrf_pkg::ST_FILL: begin
        // Bytes covered whole are written at once; partial edge bytes are read first.
        mem_en    = 1'b1;
        mem_we    = mask_full;
        mem_addr  = fill_addr;
        mem_wdata = val ? bfrf_pkg::BYTE_ONES : bfrf_pkg::BYTE_ZEROS;
      end
      bfrf_pkg::ST_FILL_WR: begin
        mem_en = 1'b1;
        mem_we = 1'b1;
      end
      default: begin
        mem_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bfrf_pkg::ST_CLEAR;
      clr_cnt   <= '0;
      clr_resp  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == bfrf_pkg::ST_CLEAR) begin
        clr_cnt <= (clr_cnt == ClrLast) ? '0 : clr_cnt + AddrW'(1);
      end
      if (state == bfrf_pkg::ST_IDLE && req.valid) begin
        clr_resp <= 1'b1;
        clr_cnt  <= '0;
      end
      if (state == bfrf_pkg::ST_RESP && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      bfrf_pkg::ST_IDLE: begin
        if (req.valid) begin
          rtype   <= bfrf_pkg::req_type_t'(req.req_type);
          px      <= req.pos_x;
          py      <= req.pos_y;
          rw      <= req.rect_width;
          rh      <= req.rect_height;
          val     <= req.pixel_in;
          res_pix <= 1'b0;
          res_err <= 1'b0;
        end
      end
      bfrf_pkg::ST_MUL: begin
        lim_prod  <= 17'(n) * 17'(geom.stride);
        base_prod <= 15'(py) * 15'(geom.stride);
      end
      bfrf_pkg::ST_EVAL: begin
        cur_addr <= pix_addr;
        cur_mask <= bfrf_pkg::LEFT_BIT >> px[2:0];
        fb       <= SW'(px[bfrf_pkg::POS_X_W-1:3]);
        b        <= SW'(px[bfrf_pkg::POS_X_W-1:3]);
        lb       <= last[9:3];
        lo_mask  <= bfrf_pkg::BYTE_ONES >> px[2:0];
        hi_mask  <= bfrf_pkg::BYTE_ONES << (3'd7 - last[2:0]);
        rows     <= rh;
        row_base <= AddrW'(base_prod);
        res_err  <= is_pix ? !pix_ok : !fill_ok;
      end
      bfrf_pkg::ST_PIX: begin
        if (rtype == bfrf_pkg::REQ_READ) begin
          res_pix <= |(mem_rdata & cur_mask);
        end
      end
      bfrf_pkg::ST_FILL, bfrf_pkg::ST_FILL_WR: begin
        if (state == bfrf_pkg::ST_FILL) begin
          cur_addr <= fill_addr;
          cur_mask <= fill_mask;
        end
        // Advance to the next byte once this one is written.
        if (state == bfrf_pkg::ST_FILL_WR || mask_full) begin
          if (b == lb) begin
            b        <= fb;
            rows     <= rows - bfrf_pkg::RECT_H_W'(1);
            row_base <= row_base + AddrW'(geom.stride);
          end else begin
            b <= b + SW'(1);
          end
        end
      end
      bfrf_pkg::ST_RESP: begin
        if (out_free) begin
          out_pix <= res_pix;
          out_err <= res_err;
        end
      end
      default: begin
      end
    endcase
  end

  assign rsp.valid     = out_valid;
  assign rsp.pixel_out = out_pix;
  assign rsp.status    = out_err;

endmodule

>>> hw/rtl/bfrf_checker.sv
// Port-level checker for the frame store, bound to the top level.
module bfrf_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic pixel_out,
  input logic status
);

  logic [1:0] pending;

  // Count items accepted whose result is not yet taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
    end
  end

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result valid dropped while stalled");

  a_hold_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(status) && $stable(pixel_out))
    else $error("result payload changed while stalled");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 2'd0)
    else $error("result shown with no item outstanding");

  a_pix_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && pixel_out |-> !status)
    else $error("pixel value set on an error result");

  a_reset_busy: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("item taken during the clearing pass after reset");

endmodule

bind bitplane_framebuffer_rect_fill bfrf_checker u_bfrf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (req.valid),
  .in_ready  (req.ready),
  .out_valid (rsp.valid),
  .out_ready (rsp.ready),
  .pixel_out (rsp.pixel_out),
  .status    (rsp.status)
);
